FILE: src/rmf_pkg.sv
// rmf_pkg: shared constants and controller/datapath interface types
// for the running median filter. No dependencies.
package rmf_pkg;

    // default configuration
    localparam int WINDOW_DEF      = 5;
    localparam int SAMPLE_BITS_DEF = 16;

    // fixed width of the sample and median ports
    localparam int VALUE_BITS = 16;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;      // store the incoming sample, restart the candidate index
        logic scan_rd;     // read address comes from the scan index, else the candidate index
        logic cand_latch;  // latch the read data as candidate, clear rank counters
        logic scan_cmp;    // compare the read data against the candidate
        logic cand_next;   // move on to the next candidate
        logic out_load;    // load the candidate into the output register
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic scan_last;   // the compare in progress is for the last stored entry
        logic hit;         // the candidate sits at the median position
        logic out_free;    // the output register can take a new result
    } t_dp_status;

endpackage

FILE: src/rmf_ctrl.sv
// rmf_ctrl: sequencing state machine of the running median filter.
// Depends on rmf_pkg (command and status types).
module rmf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  rmf_pkg::t_dp_status i_status,
    output rmf_pkg::t_dp_cmd    o_cmd
);
    import rmf_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CRD   = 7'b0000010,
        S_CLT   = 7'b0000100,
        S_SRD   = 7'b0001000,
        S_SCMP  = 7'b0010000,
        S_CHK   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready      = 1'b1;
                o_cmd.accept = i_valid;
                if (i_valid) begin
                    n_state = S_CRD;
                end
            end
            S_CRD: begin
                n_state = S_CLT;
            end
            S_CLT: begin
                o_cmd.cand_latch = 1'b1;
                n_state          = S_SRD;
            end
            S_SRD: begin
                o_cmd.scan_rd = 1'b1;
                n_state       = S_SCMP;
            end
            S_SCMP: begin
                o_cmd.scan_cmp = 1'b1;
                n_state        = i_status.scan_last ? S_CHK : S_SRD;
            end
            S_CHK: begin
                if (i_status.hit) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.cand_next = 1'b1;
                    n_state         = S_CRD;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: src/rmf_dp.sv
// rmf_dp: sample ring, rank counters and output register of the running
// median filter. Depends on rmf_pkg (command and status types, widths).
module rmf_dp #(
    parameter int WINDOW      = rmf_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = rmf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rmf_pkg::t_dp_cmd               i_cmd,
    output rmf_pkg::t_dp_status            o_status,
    input  logic [rmf_pkg::VALUE_BITS-1:0] i_sample_value,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [rmf_pkg::VALUE_BITS-1:0] o_median_value
);
    import rmf_pkg::*;

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(WINDOW - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(WINDOW);

    logic [SAMPLE_BITS-1:0] r_mem [WINDOW];
    logic [SAMPLE_BITS-1:0] r_rd_data;
    logic [SAMPLE_BITS-1:0] r_cand;
    logic [IDX_W-1:0]       r_slot;
    logic [CNT_W-1:0]       r_count;
    logic [IDX_W-1:0]       r_cand_idx;
    logic [IDX_W-1:0]       r_scan_idx;
    logic [CNT_W-1:0]       r_less;
    logic [CNT_W-1:0]       r_eq;
    logic                   r_out_valid;
    logic [VALUE_BITS-1:0]  r_out_data;

    logic [IDX_W-1:0]       w_rd_addr;
    logic [SAMPLE_BITS-1:0] w_sample;
    logic [CNT_W-1:0]       w_mid;
    logic [CNT_W:0]         w_upper;

    assign w_sample  = SAMPLE_BITS'(i_sample_value);
    assign w_rd_addr = i_cmd.scan_rd ? r_scan_idx : r_cand_idx;

    // ring memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mem[r_slot] <= w_sample;
        end
        r_rd_data <= r_mem[w_rd_addr];
    end

    // write slot and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_count <= '0;
        end else if (i_cmd.accept) begin
            r_slot <= (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;
            if (r_count != FULL_CNT) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // candidate walk and rank counting
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand_idx <= '0;
            r_scan_idx <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_cand_idx <= '0;
            end else if (i_cmd.cand_next) begin
                r_cand_idx <= r_cand_idx + 1'b1;
            end
            if (i_cmd.cand_latch) begin
                r_scan_idx <= '0;
            end else if (i_cmd.scan_cmp) begin
                r_scan_idx <= r_scan_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cand_latch) begin
            r_cand <= r_rd_data;
            r_less <= '0;
            r_eq   <= '0;
        end else if (i_cmd.scan_cmp) begin
            if (r_rd_data < r_cand) begin
                r_less <= r_less + 1'b1;
            end
            if (r_rd_data == r_cand) begin
                r_eq <= r_eq + 1'b1;
            end
        end
    end

    // median position test: less <= mid < less + equal
    assign w_mid   = r_count >> 1;
    assign w_upper = {1'b0, r_less} + {1'b0, r_eq};

    assign o_status.scan_last = (CNT_W'(r_scan_idx) == (r_count - 1'b1));
    assign o_status.hit       = (r_less <= w_mid) && ({1'b0, w_mid} < w_upper);
    assign o_status.out_free  = !r_out_valid || i_ready;

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= VALUE_BITS'(r_cand);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_median_value = r_out_data;

endmodule

FILE: src/running_median_filter.sv
// running_median_filter: top level, joins the controller and the datapath.
// Depends on rmf_pkg, rmf_ctrl and rmf_dp.
//
// Usage: samples arrive on i_sample_value with i_valid/o_ready; one median
// per sample leaves on o_median_value with o_valid/i_ready. The last WINDOW
// samples are kept in a ring; before the ring is full the result is the
// median of the samples so far (upper median for an even count).
// Ranking: with n stored samples, candidates are taken in slot order from
// slot 0; each one is read and latched, then ranked by a scan of the ring
// that reads and then compares each stored entry in turn, and its rank is
// tested. The first candidate at the median position is loaded into the
// output register once that register is free.
// Throughput: one sample at a time; o_ready returns the cycle after the
// result enters the output register, so a new transaction can be taken
// while the previous result still waits there.
// Reset: synchronous, active low; clears the fill count, the write slot and
// the output valid. Stall: a held result blocks only the next result; the
// block then waits with that result computed until i_ready frees the output.
module running_median_filter #(
    parameter int WINDOW      = rmf_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = rmf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [rmf_pkg::VALUE_BITS-1:0] i_sample_value,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [rmf_pkg::VALUE_BITS-1:0] o_median_value
);
    import rmf_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // sequencing
    rmf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // storage and ranking
    rmf_dp #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_sample_value (i_sample_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_median_value (o_median_value)
    );

endmodule

FILE: src/rmf_checker.sv
// rmf_checker: port-level assertions for running_median_filter, and the
// bind that attaches them. Depends on running_median_filter's ports only.
module rmf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [15:0] o_median_value
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_median_value))
        else $error("result changed or dropped while stalled");

    // one sample at a time: busy right after a transaction
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input taken again right after a transaction");

    // the result is ranked first, so none appears directly after a transaction
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && !o_valid |=> !o_valid)
        else $error("result appeared one cycle after a transaction");

    // reset leaves the block idle and empty
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> o_ready && !o_valid)
        else $error("block not idle after reset");

endmodule

bind running_median_filter rmf_checker u_rmf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_median_value (o_median_value)
);
